/* rtl/i2c_seq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_seq_pkg
// Shared types and codes for the I2C register transaction sequencer: item
// actions, engine status codes, engine commands and the result record.
// ----------------------------------------------------------------------------
package i2c_seq_pkg;

   // default depth of the write byte buffer
   localparam int BUF_DEPTH_DEFAULT = 256;

   // kinds of input item
   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_BEGIN  = 2'd1,
      ACT_STATUS = 2'd2
   } action_type;

   // commands issued to the byte engine
   typedef enum logic [2:0] {
      CMD_START     = 3'd0,
      CMD_SEND      = 3'd1,
      CMD_READ_ACK  = 3'd2,
      CMD_READ_NACK = 3'd3,
      CMD_STOP      = 3'd4,
      CMD_RELEASE   = 3'd5
   } cmd_type;

   // engine status codes, after masking off the low three bits
   localparam logic [7:0] STATUS_MASK     = 8'hf8;
   localparam logic [7:0] ST_START        = 8'h08;
   localparam logic [7:0] ST_RESTART      = 8'h10;
   localparam logic [7:0] ST_SLAW_ACK     = 8'h18;
   localparam logic [7:0] ST_SLAW_NACK    = 8'h20;
   localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
   localparam logic [7:0] ST_DATA_TX_NACK = 8'h30;
   localparam logic [7:0] ST_ARB_LOST     = 8'h38;
   localparam logic [7:0] ST_SLAR_ACK     = 8'h40;
   localparam logic [7:0] ST_SLAR_NACK    = 8'h48;
   localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
   localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;

   // one result beat
   typedef struct packed {
      cmd_type    command;
      logic [7:0] tx_byte;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       done_res;
      logic       failed;
   } result_type;

endpackage

/* rtl/i2c_seq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_seq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// A read in the same cycle as a write to the same address returns old data.
// ----------------------------------------------------------------------------
module i2c_seq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/i2c_register_transaction_sequencer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_transaction_sequencer_core
// Turns load, begin and engine status beats into byte engine commands for one
// register write or register read on an I2C bus.
// ----------------------------------------------------------------------------
// Takes one request beat per clock. A beat is captured in an input register,
// decided by a single pass of logic while it is held there and placed in the
// response register as it leaves, so a response passes through the input
// register and the response register, and the block sustains one beat per
// cycle while rsp_ready is high. Write bytes are held in a BUF_DEPTH-entry
// RAM; the entry to be sent is read at the edge that captures the status beat,
// so the byte is ready in the decision cycle. Load beats, status beats while
// idle, bus error and unknown codes and the unused action produce no response.
// The slave address register is written through csr_write_enable/csr_write_data
// and should only change while no transaction is in flight.
module i2c_register_transaction_sequencer_core
   import i2c_seq_pkg::*;
#(
   parameter int BUF_DEPTH = BUF_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_write_enable,
   input  logic [6:0] csr_write_data,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic       req_read_not_write,
   input  logic [7:0] req_sub_address,
   input  logic [7:0] req_length,
   input  logic [7:0] req_status,
   input  logic [7:0] req_byte_in,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_command,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_rx_valid,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_done_res,
   output logic       rsp_failed
);

   localparam int AddrWidth = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int CntWidth  = $clog2(BUF_DEPTH + 1);
   localparam int SendWidth = (AddrWidth > 8) ? AddrWidth : 8;

   // configuration register
   logic [6:0] slave_address_ff;

   // input register
   logic       s1_valid_ff;
   logic [1:0] s1_action_ff;
   logic       s1_rnw_ff;
   logic [7:0] s1_sub_ff;
   logic [7:0] s1_len_ff;
   logic [7:0] s1_status_ff;
   logic [7:0] s1_byte_ff;

   // transaction state
   logic                busy_ff,      busy_in;
   logic                is_read_ff,   is_read_in;
   logic [7:0]          target_ff,    target_in;
   logic [7:0]          remaining_ff, remaining_in;
   logic [7:0]          send_idx_ff,  send_idx_in;
   logic [CntWidth-1:0] load_cnt_ff,  load_cnt_in;

   // buffer read side
   logic                 rd_in_range_ff;
   logic                 rd_bypass_ff;
   logic [7:0]           bypass_data_ff;
   logic [7:0]           ram_rd_data;
   logic [7:0]           buf_byte;
   logic [AddrWidth-1:0] ram_rd_addr;
   logic [SendWidth-1:0] send_ext;
   logic                 ram_we;
   logic [AddrWidth-1:0] ram_wr_addr;

   // response register
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type res_in;
   logic       res_valid;

   // handshakes
   logic       req_fire;
   logic       s1_fire;
   logic       out_free;
   logic [7:0] st;
   logic [7:0] rem_dec;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && (!res_valid || out_free);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   // configuration write
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= '0;
      end else if (csr_write_enable) begin
         slave_address_ff <= csr_write_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_action_ff <= req_action;
         s1_rnw_ff    <= req_read_not_write;
         s1_sub_ff    <= req_sub_address;
         s1_len_ff    <= req_length;
         s1_status_ff <= req_status;
         s1_byte_ff   <= req_byte_in;
      end
   end

   // buffered byte, with forwarding of a load in the same cycle as the read
   assign buf_byte = !rd_in_range_ff ? 8'h00 :
                     rd_bypass_ff    ? bypass_data_ff : ram_rd_data;

   assign st      = s1_status_ff & STATUS_MASK;
   assign rem_dec = (remaining_ff != 8'h00) ? (remaining_ff - 8'h01) : 8'h00;

   // per-beat decision
   always_comb begin
      busy_in      = busy_ff;
      is_read_in   = is_read_ff;
      target_in    = target_ff;
      remaining_in = remaining_ff;
      send_idx_in  = send_idx_ff;
      load_cnt_in  = load_cnt_ff;
      ram_we       = 1'b0;
      res_valid    = 1'b0;
      res_in       = '{command: CMD_START, tx_byte: 8'h00, rx_valid: 1'b0,
                       rx_byte: 8'h00, done_res: 1'b0, failed: 1'b0};
      case (s1_action_ff)
         ACT_LOAD: begin
            if (32'(load_cnt_ff) < 32'(BUF_DEPTH)) begin
               ram_we      = s1_valid_ff;
               load_cnt_in = load_cnt_ff + 1'b1;
            end
         end
         ACT_BEGIN: begin
            busy_in        = 1'b1;
            is_read_in     = s1_rnw_ff;
            target_in      = s1_sub_ff;
            remaining_in   = s1_len_ff;
            send_idx_in    = 8'h00;
            res_valid      = 1'b1;
            res_in.command = CMD_START;
         end
         ACT_STATUS: begin
            if (busy_ff) begin
               case (st)
                  ST_START: begin
                     res_valid      = 1'b1;
                     res_in.command = CMD_SEND;
                     res_in.tx_byte = {slave_address_ff, 1'b0};
                  end
                  ST_RESTART: begin
                     res_valid      = 1'b1;
                     res_in.command = CMD_SEND;
                     res_in.tx_byte = {slave_address_ff, 1'b1};
                  end
                  ST_SLAW_ACK: begin
                     res_valid      = 1'b1;
                     res_in.command = CMD_SEND;
                     res_in.tx_byte = target_ff;
                  end
                  ST_DATA_TX_ACK: begin
                     res_valid = 1'b1;
                     if (is_read_ff) begin
                        res_in.command = CMD_START;
                     end else if (remaining_ff == 8'h00) begin
                        busy_in         = 1'b0;
                        load_cnt_in     = '0;
                        res_in.command  = CMD_STOP;
                        res_in.done_res = 1'b1;
                     end else begin
                        remaining_in   = rem_dec;
                        send_idx_in    = send_idx_ff + 8'h01;
                        res_in.command = CMD_SEND;
                        res_in.tx_byte = buf_byte;
                     end
                  end
                  ST_SLAR_ACK: begin
                     res_valid      = 1'b1;
                     res_in.command = (remaining_ff > 8'h01) ? CMD_READ_ACK : CMD_READ_NACK;
                  end
                  ST_DATA_RX_ACK: begin
                     res_valid       = 1'b1;
                     remaining_in    = rem_dec;
                     res_in.command  = (rem_dec > 8'h01) ? CMD_READ_ACK : CMD_READ_NACK;
                     res_in.rx_valid = 1'b1;
                     res_in.rx_byte  = s1_byte_ff;
                  end
                  ST_DATA_RX_NACK: begin
                     res_valid       = 1'b1;
                     busy_in         = 1'b0;
                     load_cnt_in     = '0;
                     res_in.command  = CMD_STOP;
                     res_in.rx_valid = 1'b1;
                     res_in.rx_byte  = s1_byte_ff;
                     res_in.done_res = 1'b1;
                  end
                  ST_SLAW_NACK, ST_DATA_TX_NACK, ST_SLAR_NACK: begin
                     res_valid       = 1'b1;
                     busy_in         = 1'b0;
                     load_cnt_in     = '0;
                     res_in.command  = CMD_STOP;
                     res_in.done_res = 1'b1;
                     res_in.failed   = 1'b1;
                  end
                  ST_ARB_LOST: begin
                     res_valid       = 1'b1;
                     busy_in         = 1'b0;
                     load_cnt_in     = '0;
                     res_in.command  = CMD_RELEASE;
                     res_in.done_res = 1'b1;
                     res_in.failed   = 1'b1;
                  end
                  default: begin
                     res_valid = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
      if (!s1_valid_ff) begin
         res_valid = 1'b0;
      end
   end

   // transaction state update
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         is_read_ff   <= 1'b0;
         target_ff    <= '0;
         remaining_ff <= '0;
         send_idx_ff  <= '0;
         load_cnt_ff  <= '0;
      end else if (s1_fire) begin
         busy_ff      <= busy_in;
         is_read_ff   <= is_read_in;
         target_ff    <= target_in;
         remaining_ff <= remaining_in;
         send_idx_ff  <= send_idx_in;
         load_cnt_ff  <= load_cnt_in;
      end
   end

   // buffer read is launched as a beat is captured, at the index it will see
   assign send_ext    = SendWidth'(s1_fire ? send_idx_in : send_idx_ff);
   assign ram_rd_addr = send_ext[AddrWidth-1:0];
   assign ram_wr_addr = load_cnt_ff[AddrWidth-1:0];

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_in_range_ff <= 32'(send_ext) < 32'(BUF_DEPTH);
         rd_bypass_ff   <= ram_we && s1_fire && (ram_wr_addr == ram_rd_addr);
         bypass_data_ff <= s1_byte_ff;
      end
   end

   i2c_seq_ram #(
      .WIDTH (8),
      .DEPTH (BUF_DEPTH)
   ) u_write_buffer (
      .clock   (clock),
      .wr_en   (ram_we && s1_fire),
      .wr_addr (ram_wr_addr),
      .wr_data (s1_byte_ff),
      .rd_en   (req_fire),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && res_valid) begin
         rsp_ff <= res_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_command  = rsp_ff.command;
   assign rsp_tx_byte  = rsp_ff.tx_byte;
   assign rsp_rx_valid = rsp_ff.rx_valid;
   assign rsp_rx_byte  = rsp_ff.rx_byte;
   assign rsp_done_res = rsp_ff.done_res;
   assign rsp_failed   = rsp_ff.failed;

`ifndef NO_ASSERTIONS
   // a finishing beat leaves the sequencer idle with the load pointer cleared
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && res_valid && res_in.done_res) |=> (!busy_ff && load_cnt_ff == '0))
      else $error("finishing beat did not clear busy and load pointer");

   // the load pointer never runs past the buffer
   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      32'(load_cnt_ff) <= 32'(BUF_DEPTH))
      else $error("load pointer beyond buffer depth");

   // a failure always ends the transaction
   a_fail_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_ff.failed || rsp_ff.done_res))
      else $error("failed response without done");

   // received data only travels with a read or a stop command
   a_rx_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.rx_valid) |->
         (rsp_ff.command == CMD_READ_ACK || rsp_ff.command == CMD_READ_NACK ||
          rsp_ff.command == CMD_STOP))
      else $error("received byte with unexpected command");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the I2C register transaction sequencer. Load, begin
// and engine status beats are driven into the request channel. Each accepted
// beat updates a local model of the sequencer, which queues the command it
// expects back. Every response beat is compared field by field against the
// oldest queued command. The run covers directed corner cases, a full write
// buffer, long transfers and random register reads and writes with injected
// faults, noise and random pacing on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import i2c_seq_pkg::*;

   localparam int          BUF_DEPTH     = BUF_DEPTH_DEFAULT;
   localparam int          CYCLE_LIMIT   = 500000;
   localparam int          SETTLE_CYCLES = 4;
   localparam logic [1:0]  ACT_UNUSED    = 2'd3;
   localparam logic [7:0]  ST_BUS_ERROR  = 8'h00;

   // dut ports, inputs known from time zero
   logic       clock              = 1'b0;
   logic       reset              = 1'b1;
   logic       csr_write_enable   = 1'b0;
   logic [6:0] csr_write_data     = '0;
   logic       req_valid          = 1'b0;
   logic       req_ready;
   logic [1:0] req_action         = '0;
   logic       req_read_not_write = 1'b0;
   logic [7:0] req_sub_address    = '0;
   logic [7:0] req_length         = '0;
   logic [7:0] req_status         = '0;
   logic [7:0] req_byte_in        = '0;
   logic       rsp_valid;
   logic       rsp_ready          = 1'b0;
   logic [2:0] rsp_command;
   logic [7:0] rsp_tx_byte;
   logic       rsp_rx_valid;
   logic [7:0] rsp_rx_byte;
   logic       rsp_done_res;
   logic       rsp_failed;

   // sequencer model state
   logic [6:0]  slave_addr_model = '0;
   bit          txn_busy;
   bit          reading;
   logic [7:0]  reg_addr;
   logic [7:0]  bytes_left;
   logic [7:0]  send_ptr;
   int unsigned load_ptr;
   logic [7:0]  byte_store   [BUF_DEPTH];
   bit          entry_loaded [BUF_DEPTH];
   cmd_type     last_cmd = CMD_START;

   // commands still to come back from the dut
   result_type  expected_cmds [$];

   // run control and statistics
   bit          idle_on;
   bit          disturb_on;
   int unsigned stall_left;
   int unsigned cycle_count;
   int unsigned beats_sent;
   int unsigned beats_checked;
   int unsigned txn_ended;
   int unsigned txn_failed;
   int unsigned mismatch_count;

   i2c_register_transaction_sequencer_core dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_read_not_write (req_read_not_write),
      .req_sub_address    (req_sub_address),
      .req_length         (req_length),
      .req_status         (req_status),
      .req_byte_in        (req_byte_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_command        (rsp_command),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_rx_valid       (rsp_rx_valid),
      .rsp_rx_byte        (rsp_rx_byte),
      .rsp_done_res       (rsp_done_res),
      .rsp_failed         (rsp_failed)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d commands outstanding", cycle_count,
                  expected_cmds.size());
         $display("i2c_register_transaction_sequencer_core verification failed");
         $finish;
      end
   end

   // one line per mismatch
   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   // ends the current transfer in the model
   function automatic void close_txn(input bit fail);
      txn_busy = 1'b0;
      load_ptr = 0;
      txn_ended++;
      if (fail)
         txn_failed++;
   endfunction

   // model of the sequencer: applies one accepted beat, queues any command
   function automatic void predict_command(input logic [1:0] act, input logic rnw,
                                           input logic [7:0] sub, input logic [7:0] len,
                                           input logic [7:0] st, input logic [7:0] byt);
      logic [7:0] code;
      result_type cmd;
      bit         emit;
      code = st & STATUS_MASK;
      cmd  = '0;
      emit = 1'b0;
      case (act)
         ACT_LOAD: begin
            if (load_ptr < BUF_DEPTH) begin
               byte_store[load_ptr]   = byt;
               entry_loaded[load_ptr] = 1'b1;
               load_ptr++;
            end
         end
         ACT_BEGIN: begin
            // also the way out of a hung transfer: load pointer is kept
            txn_busy    = 1'b1;
            reading     = rnw;
            reg_addr    = sub;
            bytes_left  = len;
            send_ptr    = '0;
            cmd.command = CMD_START;
            emit        = 1'b1;
         end
         ACT_STATUS: begin
            if (txn_busy) begin
               emit = 1'b1;
               case (code)
                  ST_START: begin
                     cmd.command = CMD_SEND;
                     cmd.tx_byte = {slave_addr_model, 1'b0};
                  end
                  ST_RESTART: begin
                     cmd.command = CMD_SEND;
                     cmd.tx_byte = {slave_addr_model, 1'b1};
                  end
                  ST_SLAW_ACK: begin
                     cmd.command = CMD_SEND;
                     cmd.tx_byte = reg_addr;
                  end
                  ST_DATA_TX_ACK: begin
                     if (reading) begin
                        cmd.command = CMD_START;
                     end else if (bytes_left == 0) begin
                        close_txn(1'b0);
                        cmd.command  = CMD_STOP;
                        cmd.done_res = 1'b1;
                     end else begin
                        bytes_left--;
                        cmd.command = CMD_SEND;
                        if (send_ptr < BUF_DEPTH)
                           cmd.tx_byte = byte_store[send_ptr];
                        send_ptr++;
                     end
                  end
                  ST_SLAR_ACK: begin
                     cmd.command = (bytes_left > 1) ? CMD_READ_ACK : CMD_READ_NACK;
                  end
                  ST_DATA_RX_ACK: begin
                     if (bytes_left > 0)
                        bytes_left--;
                     cmd.command  = (bytes_left > 1) ? CMD_READ_ACK : CMD_READ_NACK;
                     cmd.rx_valid = 1'b1;
                     cmd.rx_byte  = byt;
                  end
                  ST_DATA_RX_NACK: begin
                     close_txn(1'b0);
                     cmd.command  = CMD_STOP;
                     cmd.rx_valid = 1'b1;
                     cmd.rx_byte  = byt;
                     cmd.done_res = 1'b1;
                  end
                  ST_SLAW_NACK, ST_DATA_TX_NACK, ST_SLAR_NACK: begin
                     close_txn(1'b1);
                     cmd.command  = CMD_STOP;
                     cmd.done_res = 1'b1;
                     cmd.failed   = 1'b1;
                  end
                  ST_ARB_LOST: begin
                     close_txn(1'b1);
                     cmd.command  = CMD_RELEASE;
                     cmd.done_res = 1'b1;
                     cmd.failed   = 1'b1;
                  end
                  // bus error and unknown codes leave everything alone
                  default: emit = 1'b0;
               endcase
            end
         end
         default: ;
      endcase
      if (emit) begin
         expected_cmds.push_back(cmd);
         last_cmd = cmd.command;
      end
   endfunction

   // sends one request beat, after a random gap when idle_on is set, and waits for it to be taken
   task automatic send_beat(input logic [1:0] act, input logic rnw, input logic [7:0] sub,
                            input logic [7:0] len, input logic [7:0] st,
                            input logic [7:0] byt);
      int unsigned gap;
      logic [7:0]  st_out;
      st_out = st;
      // never let a write send a buffer entry that was never loaded
      if (act == ACT_STATUS && (st & STATUS_MASK) == ST_DATA_TX_ACK && txn_busy &&
          !reading && bytes_left != 0 && !entry_loaded[send_ptr])
         st_out = (st & ~STATUS_MASK) | ST_DATA_TX_NACK;
      gap = idle_on ? $urandom_range(4, 0) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_action         <= act;
      req_read_not_write <= rnw;
      req_sub_address    <= sub;
      req_length         <= len;
      req_status         <= st_out;
      req_byte_in        <= byt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      predict_command(act, rnw, sub, len, st_out, byt);
   endtask

   task automatic send_load(input logic [7:0] byt);
      send_beat(ACT_LOAD, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), byt);
   endtask

   task automatic send_begin(input logic rnw, input logic [7:0] sub, input logic [7:0] len);
      send_beat(ACT_BEGIN, rnw, sub, len, 8'($urandom), 8'($urandom));
   endtask

   // status beat with random don't-care low bits and received byte
   task automatic send_status(input logic [7:0] code);
      send_beat(ACT_STATUS, 1'($urandom), 8'($urandom), 8'($urandom),
                code | 8'($urandom_range(7, 0)), 8'($urandom));
   endtask

   function automatic logic [7:0] random_fault_code();
      case ($urandom_range(3, 0))
         0:       return ST_SLAW_NACK;
         1:       return ST_DATA_TX_NACK;
         2:       return ST_SLAR_NACK;
         default: return ST_ARB_LOST;
      endcase
   endfunction

   // now and then slips a stray beat into a transfer; lost means the flow is gone
   task automatic disturb(output bit lost);
      lost = 1'b0;
      if (disturb_on && $urandom_range(99, 0) < 7) begin
         case ($urandom_range(5, 0))
            0: send_load(8'($urandom));
            1: send_status(8'($urandom_range(31, 12) << 3));
            2: send_status(ST_BUS_ERROR);
            3: send_beat(ACT_UNUSED, 1'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
            4: send_status(random_fault_code());
            default: begin
               send_begin(1'($urandom), 8'($urandom), 8'($urandom_range(6, 0)));
               lost = 1'b1;
            end
         endcase
      end
      lost = lost || !txn_busy;
   endtask

   // plays the byte engine through one register write or read
   task automatic run_transfer(input bit rd, input logic [7:0] len,
                               input int unsigned max_data);
      logic [7:0]  prelude [5];
      int unsigned n_pre;
      int unsigned n_data;
      bit          lost;
      prelude = '{ST_START, ST_SLAW_ACK, ST_DATA_TX_ACK, ST_RESTART, ST_SLAR_ACK};
      n_pre   = rd ? 5 : 2;
      n_data  = 0;
      send_begin(rd, 8'($urandom), len);
      for (int i = 0; i < n_pre; i++) begin
         disturb(lost);
         if (lost)
            return;
         send_status(prelude[i]);
      end
      while (txn_busy) begin
         disturb(lost);
         if (lost)
            return;
         if (n_data == max_data) begin
            send_status(ST_ARB_LOST);
            return;
         end
         if (!rd)
            send_status(ST_DATA_TX_ACK);
         else if (last_cmd == CMD_READ_ACK)
            send_status(ST_DATA_RX_ACK);
         else
            send_status(ST_DATA_RX_NACK);
         n_data++;
      end
   endtask

   // waits until every expected command is back and the pipeline is empty
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // slave address write, only with nothing in flight
   task automatic set_device_address(input logic [6:0] addr);
      if (txn_busy)
         send_status(ST_ARB_LOST);
      settle_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= addr;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      slave_addr_model = addr;
   endtask

   // corner cases, back to back
   task automatic test_directed();
      idle_on    = 1'b0;
      disturb_on = 1'b0;
      set_device_address(7'h7f);
      // two-byte write of the byte extremes to the top register
      send_load(8'h00);
      send_load(8'hff);
      send_begin(1'b0, 8'hff, 8'd2);
      send_status(ST_START);
      send_status(ST_SLAW_ACK);
      repeat (3) send_status(ST_DATA_TX_ACK);
      // zero-length read: nack read right after SLA+R, its byte still passed out
      send_begin(1'b1, 8'h00, 8'd0);
      send_status(ST_START);
      send_status(ST_SLAW_ACK);
      send_status(ST_DATA_TX_ACK);
      send_status(ST_RESTART);
      send_status(ST_SLAR_ACK);
      send_beat(ACT_STATUS, 1'b1, 8'hff, 8'hff, ST_DATA_RX_NACK | 8'h07, 8'hff);
      // status while idle and the unused action are dropped
      send_status(ST_START);
      send_beat(ACT_UNUSED, 1'b1, 8'hff, 8'hff, 8'hff, 8'hff);
      // bus error and unknown code while busy produce nothing
      send_begin(1'b1, 8'h5a, 8'd255);
      send_status(ST_BUS_ERROR);
      send_status(8'hf8);
      send_status(ST_START);
      // begin while busy abandons the read, then SLA+W nack ends the write
      send_begin(1'b0, 8'ha5, 8'd0);
      send_status(ST_SLAW_NACK);
   endtask

   // write buffer filled past its depth, longest write, long read cut short
   task automatic test_long_transfers();
      idle_on    = 1'b1;
      disturb_on = 1'b0;
      set_device_address(7'h2a);
      for (int i = 0; i < BUF_DEPTH + 2; i++)
         send_load(8'($urandom));
      run_transfer(1'b0, 8'd255, 1000);
      run_transfer(1'b1, 8'd255, 30);
   endtask

   // random writes, reads and noise over several addresses and pacing modes
   task automatic test_random_traffic();
      int unsigned stop_at;
      int unsigned n_load;
      logic [7:0]  len;
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 0)
            set_device_address(7'h00);
         else if (phase == 1)
            set_device_address(7'h7f);
         else
            set_device_address(7'($urandom));
         idle_on    = (phase % 2) == 0;
         disturb_on = 1'b1;
         stop_at    = beats_sent + 140;
         while (beats_sent < stop_at) begin
            case ($urandom_range(9, 0))
               0, 1, 2, 3: begin
                  n_load = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 7)
                                                       : $urandom_range(6, 0);
                  repeat (n_load) send_load(8'($urandom));
                  len = ($urandom_range(7, 0) == 0) ? 8'($urandom_range(40, 0)) : 8'(n_load);
                  run_transfer(1'b0, len, 1000);
               end
               4, 5, 6, 7, 8: begin
                  len = ($urandom_range(3, 0) == 0) ? 8'($urandom_range(24, 0))
                                                    : 8'($urandom_range(4, 0));
                  run_transfer(1'b1, len, 1000);
               end
               default: begin
                  repeat ($urandom_range(3, 1))
                     send_beat(2'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom), 8'($urandom));
               end
            endcase
         end
      end
   endtask

   // response back-pressure: a fresh stall is drawn after every beat
   always @(posedge clock) begin : rsp_pacing
      int unsigned stall;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         stall = idle_on ? $urandom_range(4, 0) : 0;
         stall_left <= stall;
         rsp_ready  <= (stall == 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= (stall_left == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // response checker: every beat against the oldest expected command
   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_checked++;
         if (expected_cmds.size() == 0) begin
            report_mismatch("unexpected response beat, command", int'(rsp_command), 0);
         end else begin
            want = expected_cmds.pop_front();
            if (rsp_command !== want.command)
               report_mismatch("command", int'(rsp_command), int'(want.command));
            if (rsp_tx_byte !== want.tx_byte)
               report_mismatch("tx_byte", int'(rsp_tx_byte), int'(want.tx_byte));
            if (rsp_rx_valid !== want.rx_valid)
               report_mismatch("rx_valid", int'(rsp_rx_valid), int'(want.rx_valid));
            if (rsp_rx_byte !== want.rx_byte)
               report_mismatch("rx_byte", int'(rsp_rx_byte), int'(want.rx_byte));
            if (rsp_done_res !== want.done_res)
               report_mismatch("done_res", int'(rsp_done_res), int'(want.done_res));
            if (rsp_failed !== want.failed)
               report_mismatch("failed", int'(rsp_failed), int'(want.failed));
         end
      end
   end

   // test sequence
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_long_transfers();
      test_random_traffic();
      settle_idle();
      repeat (8) @(posedge clock);
      $display("run covered %0d request beats and %0d checked response beats",
               beats_sent, beats_checked);
      $display("%0d transfers ended, %0d of them failed; %0d mismatches",
               txn_ended, txn_failed, mismatch_count);
      if (mismatch_count == 0)
         $display("i2c_register_transaction_sequencer_core verification clean");
      else
         $display("i2c_register_transaction_sequencer_core verification failed");
      $finish;
   end

endmodule
